// ===== src/scfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg - serial command frame parser package
// phase codes, character constants and the state/result structs shared by
// the parser step logic and the top level
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned IDX_W = 7;
  localparam int unsigned BYTE_W = 8;

  // characters of the frame syntax
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;  // 'C'
  localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;  // 'D'
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;  // carriage return
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_C       = 4'd1,
    PH_M       = 4'd2,
    PH_D       = 4'd3,
    PH_CLOSE   = 4'd4,
    PH_CODE    = 4'd5,
    PH_TENS    = 4'd6,
    PH_UNITS   = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [IDX_W-1:0]  remaining;
    logic [BYTE_W-1:0] code;
    logic [IDX_W-1:0]  length;
  } state_t;

  typedef struct packed {
    logic              data_valid;
    logic [IDX_W-1:0]  data_index;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_done;
    logic [BYTE_W-1:0] command_code;
    logic [IDX_W-1:0]  command_length;
    logic              overflow;
  } result_t;

endpackage

// ===== src/scfp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp channel interfaces
// received byte channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface scfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [scfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        data_valid;
  logic [scfp_pkg::IDX_W-1:0]  data_index;
  logic [scfp_pkg::BYTE_W-1:0] data_byte;
  logic                        frame_done;
  logic [scfp_pkg::BYTE_W-1:0] command_code;
  logic [scfp_pkg::IDX_W-1:0]  command_length;
  logic                        overflow;

  modport source (output valid, output data_valid, output data_index, output data_byte,
                  output frame_done, output command_code, output command_length,
                  output overflow, input ready);
  modport sink (input valid, input data_valid, input data_index, input data_byte,
                input frame_done, input command_code, input command_length,
                input overflow, output ready);
endinterface

// ===== src/scfp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_step - parser step logic
// next parser state and result for one received byte
// ----------------------------------------------------------------------------
module scfp_step #(
  parameter int unsigned MAX_PAYLOAD = 34
) (
  input  scfp_pkg::state_t                state_cur,
  input  logic [scfp_pkg::BYTE_W-1:0]     rx_byte,
  output scfp_pkg::state_t                state_nxt,
  output scfp_pkg::result_t               result_nxt
);

  localparam logic [scfp_pkg::IDX_W-1:0] MaxIdx = scfp_pkg::IDX_W'(MAX_PAYLOAD);

  logic                         is_digit;
  logic [3:0]                   digit;
  logic [scfp_pkg::IDX_W-1:0]   digit_ext;
  logic [scfp_pkg::IDX_W-1:0]   tens;
  logic [scfp_pkg::IDX_W-1:0]   pay_index;
  logic                         is_cr;

  assign is_digit  = (rx_byte >= scfp_pkg::CH_ZERO) && (rx_byte <= scfp_pkg::CH_NINE);
  assign digit     = rx_byte[3:0];
  assign digit_ext = {3'b000, digit};
  // digit * 10 as two shifts
  assign tens      = (digit_ext << 3) + (digit_ext << 1);
  assign pay_index = state_cur.length - state_cur.remaining;
  assign is_cr     = (rx_byte == scfp_pkg::CH_CR);

  always_comb begin
    state_nxt                 = state_cur;
    result_nxt.data_valid     = 1'b0;
    result_nxt.data_index     = '0;
    result_nxt.data_byte      = '0;
    result_nxt.frame_done     = 1'b0;
    result_nxt.overflow       = 1'b0;

    unique case (state_cur.phase)
      scfp_pkg::PH_C: begin
        state_nxt.phase = (rx_byte == scfp_pkg::CH_C) ? scfp_pkg::PH_M : scfp_pkg::PH_IDLE;
      end
      scfp_pkg::PH_M: begin
        state_nxt.phase = (rx_byte == scfp_pkg::CH_M) ? scfp_pkg::PH_D : scfp_pkg::PH_IDLE;
      end
      scfp_pkg::PH_D: begin
        state_nxt.phase = (rx_byte == scfp_pkg::CH_D) ? scfp_pkg::PH_CLOSE : scfp_pkg::PH_IDLE;
      end
      scfp_pkg::PH_CLOSE: begin
        state_nxt.phase = (rx_byte == scfp_pkg::CH_GT) ? scfp_pkg::PH_CODE : scfp_pkg::PH_IDLE;
      end
      scfp_pkg::PH_CODE: begin
        state_nxt.code  = rx_byte;
        state_nxt.phase = scfp_pkg::PH_TENS;
      end
      scfp_pkg::PH_TENS: begin
        if (is_digit) begin
          state_nxt.remaining = tens;
          state_nxt.phase     = scfp_pkg::PH_UNITS;
        end else begin
          state_nxt.phase = scfp_pkg::PH_IDLE;
        end
      end
      scfp_pkg::PH_UNITS: begin
        if (is_digit) begin
          state_nxt.remaining = state_cur.remaining + digit_ext;
          state_nxt.length    = state_cur.remaining + digit_ext;
          state_nxt.phase     = scfp_pkg::PH_PAYLOAD;
        end else begin
          state_nxt.phase = scfp_pkg::PH_IDLE;
        end
      end
      scfp_pkg::PH_PAYLOAD: begin
        if (state_cur.remaining != '0) begin
          if (is_cr) begin
            // early cr aborts the frame
            state_nxt.phase = scfp_pkg::PH_IDLE;
          end else begin
            result_nxt.data_index = pay_index;
            result_nxt.data_byte  = rx_byte;
            result_nxt.data_valid = (pay_index < MaxIdx);
            state_nxt.remaining   = state_cur.remaining - 1'b1;
          end
        end else begin
          result_nxt.frame_done = is_cr;
          result_nxt.overflow   = is_cr && (state_cur.length > MaxIdx);
          state_nxt.phase       = scfp_pkg::PH_IDLE;
        end
      end
      default: begin
        // idle and unused codes: clear the frame and look for '<'
        state_nxt.code      = '0;
        state_nxt.length    = '0;
        state_nxt.remaining = '0;
        state_nxt.phase     = (rx_byte == scfp_pkg::CH_LT) ? scfp_pkg::PH_C
                                                           : scfp_pkg::PH_IDLE;
      end
    endcase

    result_nxt.command_code   = state_nxt.code;
    result_nxt.command_length = state_nxt.length;
  end

endmodule

// ===== src/serial_command_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser - top level
// recognises "<CMD>" code, two-digit length, payload and cr frames in a
// byte stream; one result beat for every received byte beat
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                                     | handshake
//   ---------+-----+---------------------------------------------+-----------
//   in_ch    | in  | rx_byte                                     | valid/ready
//   out_ch   | out | data_valid, data_index, data_byte,          | valid/ready
//            |     | frame_done, command_code, command_length,   |
//            |     | overflow                                    |
//
// one beat per cycle sustained while out_ch is ready; an accepted byte goes
// from the input register into the result register, parser state with it
// reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle with code, length and count cleared
// a stall on out_ch holds the result register; the input register still
// takes one more beat, after which in_ch.ready drops until out_ch drains
// ----------------------------------------------------------------------------
module serial_command_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 34
) (
  input logic              clk,
  input logic              rst_n,
  scfp_in_if.sink          in_ch,
  scfp_out_if.source       out_ch
);

  // input register
  logic                        in_valid_r;
  logic [scfp_pkg::BYTE_W-1:0] in_byte_r;

  // parser state
  scfp_pkg::state_t            state_r;
  scfp_pkg::state_t            state_nxt;

  // result register
  logic                        out_valid_r;
  scfp_pkg::result_t           result_r;
  scfp_pkg::result_t           result_nxt;

  logic                        advance;

  // a held byte moves on when the result register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  scfp_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .state_cur  (state_r),
    .rx_byte    (in_byte_r),
    .state_nxt  (state_nxt),
    .result_nxt (result_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: scfp_pkg::PH_IDLE, remaining: '0, code: '0, length: '0};
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.data_valid     = result_r.data_valid;
  assign out_ch.data_index     = result_r.data_index;
  assign out_ch.data_byte      = result_r.data_byte;
  assign out_ch.frame_done     = result_r.frame_done;
  assign out_ch.command_code   = result_r.command_code;
  assign out_ch.command_length = result_r.command_length;
  assign out_ch.overflow       = result_r.overflow;

endmodule

// ===== tb/sv/frame_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker - result checker for the serial command frame parser
// watches both channels, runs a parser of its own on every accepted byte
// beat and compares each result beat, field by field, with the oldest
// predicted one
// ----------------------------------------------------------------------------
module frame_result_checker #(
  parameter int unsigned MAX_PAYLOAD = 34
) (
  input  logic        clk,
  input  logic        rst_n,
  scfp_in_if          in_mon,
  scfp_out_if         out_mon,
  output int unsigned error_count,
  output int unsigned results_owed
);
  import scfp_pkg::*;

  // parser state as seen by the checker
  phase_t            stage;
  logic [IDX_W-1:0]  bytes_owed;
  logic [BYTE_W-1:0] held_code;
  logic [IDX_W-1:0]  held_length;

  result_t     parsed_results[$];
  int unsigned result_beats;

  task automatic log_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
    result_t          r;
    logic [IDX_W-1:0] idx;
    r = '0;
    idx = '0;
    case (stage)
      PH_C:     stage = (b == CH_C) ? PH_M : PH_IDLE;
      PH_M:     stage = (b == CH_M) ? PH_D : PH_IDLE;
      PH_D:     stage = (b == CH_D) ? PH_CLOSE : PH_IDLE;
      PH_CLOSE: stage = (b == CH_GT) ? PH_CODE : PH_IDLE;
      PH_CODE: begin
        held_code = b;
        stage = PH_TENS;
      end
      PH_TENS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          bytes_owed = IDX_W'((b - CH_ZERO) * 10);
          stage = PH_UNITS;
        end else begin
          stage = PH_IDLE;
        end
      end
      PH_UNITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          bytes_owed = IDX_W'(bytes_owed + (b - CH_ZERO));
          held_length = bytes_owed;
          stage = PH_PAYLOAD;
        end else begin
          stage = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_owed != 0) begin
          // a cr while payload is still due drops the frame
          if (b == CH_CR) begin
            stage = PH_IDLE;
          end else begin
            idx = held_length - bytes_owed;
            r.data_index = idx;
            r.data_byte = b;
            r.data_valid = (idx < MAX_PAYLOAD);
            bytes_owed = bytes_owed - 1'b1;
          end
        end else begin
          if (b == CH_CR) begin
            r.frame_done = 1'b1;
            r.overflow = (held_length > MAX_PAYLOAD);
          end
          stage = PH_IDLE;
        end
      end
      default: begin
        held_code = '0;
        held_length = '0;
        bytes_owed = '0;
        stage = (b == CH_LT) ? PH_C : PH_IDLE;
      end
    endcase
    r.command_code = held_code;
    r.command_length = held_length;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst_n) begin
      stage = PH_IDLE;
      bytes_owed = '0;
      held_code = '0;
      held_length = '0;
      parsed_results.delete();
      result_beats = 0;
      error_count = 0;
    end else begin
      // results first: a byte accepted this edge cannot already be out
      if (out_mon.valid && out_mon.ready) begin
        seen.data_valid = out_mon.data_valid;
        seen.data_index = out_mon.data_index;
        seen.data_byte = out_mon.data_byte;
        seen.frame_done = out_mon.frame_done;
        seen.command_code = out_mon.command_code;
        seen.command_length = out_mon.command_length;
        seen.overflow = out_mon.overflow;
        if (parsed_results.size() == 0) begin
          log_mismatch($sformatf("result beat %0d arrived with nothing predicted",
                                 result_beats));
        end else begin
          want = parsed_results.pop_front();
          if (seen.data_valid !== want.data_valid)
            log_mismatch($sformatf("beat %0d data_valid got %0b expected %0b",
                                   result_beats, seen.data_valid, want.data_valid));
          if (seen.data_index !== want.data_index)
            log_mismatch($sformatf("beat %0d data_index got %0d expected %0d",
                                   result_beats, seen.data_index, want.data_index));
          if (seen.data_byte !== want.data_byte)
            log_mismatch($sformatf("beat %0d data_byte got %h expected %h",
                                   result_beats, seen.data_byte, want.data_byte));
          if (seen.frame_done !== want.frame_done)
            log_mismatch($sformatf("beat %0d frame_done got %0b expected %0b",
                                   result_beats, seen.frame_done, want.frame_done));
          if (seen.command_code !== want.command_code)
            log_mismatch($sformatf("beat %0d command_code got %h expected %h",
                                   result_beats, seen.command_code, want.command_code));
          if (seen.command_length !== want.command_length)
            log_mismatch($sformatf("beat %0d command_length got %0d expected %0d",
                                   result_beats, seen.command_length,
                                   want.command_length));
          if (seen.overflow !== want.overflow)
            log_mismatch($sformatf("beat %0d overflow got %0b expected %0b",
                                   result_beats, seen.overflow, want.overflow));
        end
        result_beats++;
      end
      if (in_mon.valid && in_mon.ready) parsed_results.push_back(parse_byte(in_mon.rx_byte));
    end
    results_owed = parsed_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - serial command frame parser
// drives byte beats built from frames (good ones, aborted ones and line
// noise) with random idle bursts on both channels; a separate checker
// predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
  import scfp_pkg::*;

  localparam int unsigned MAX_PAYLOAD    = 34;
  localparam int unsigned RANDOM_BYTES   = 600;
  localparam int unsigned CALM_TAIL      = 80;   // closing bytes with no idling
  localparam int unsigned WATCHDOG_LIMIT = 300;  // cycles with no beat at all
  localparam int unsigned DRAIN_CYCLES   = 8;    // idle time after the last result is back

  // shapes of byte sequence fed to the parser
  typedef enum logic [2:0] {
    FR_GOOD,        // complete frame closed by cr
    FR_EARLY_CR,    // cr while payload is still due
    FR_TRAILING,    // non-cr byte after the payload
    FR_BAD_DIGIT,   // length byte that is not a digit
    FR_BAD_HEADER,  // start marker broken part way
    FR_NOISE        // a few arbitrary bytes
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  scfp_in_if  in_ch ();
  scfp_out_if out_ch ();

  int unsigned error_count;
  int unsigned results_owed;

  serial_command_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frame_result_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  logic [BYTE_W-1:0] rx_stream[$];
  logic [BYTE_W-1:0] frame_head[5] = '{CH_LT, CH_C, CH_M, CH_D, CH_GT};
  bit                calm = 1'b0;
  int unsigned       idle_cycles = 0;

  // append one byte sequence of the given shape to the stream
  // len must be at least 1 for an early cr
  task automatic queue_frame(input frame_kind_t kind, input int unsigned len,
                             input logic [BYTE_W-1:0] code);
    int unsigned       cut;
    int unsigned       i;
    logic [BYTE_W-1:0] b;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) rx_stream.push_back(BYTE_W'($urandom));
      return;
    end
    if (kind == FR_BAD_HEADER) begin
      cut = $urandom_range(1, 4);
      for (i = 0; i < cut; i++) rx_stream.push_back(frame_head[i]);
      do b = BYTE_W'($urandom); while (b == frame_head[cut]);
      rx_stream.push_back(b);
      return;
    end
    for (i = 0; i < 5; i++) rx_stream.push_back(frame_head[i]);
    rx_stream.push_back(code);
    if (kind == FR_BAD_DIGIT) begin
      // the bad byte lands on either the tens or the units position
      if ($urandom_range(0, 1)) rx_stream.push_back(CH_ZERO + BYTE_W'(len / 10));
      do b = BYTE_W'($urandom); while (b >= CH_ZERO && b <= CH_NINE);
      rx_stream.push_back(b);
      return;
    end
    rx_stream.push_back(CH_ZERO + BYTE_W'(len / 10));
    rx_stream.push_back(CH_ZERO + BYTE_W'(len % 10));
    cut = (kind == FR_EARLY_CR) ? $urandom_range(0, len - 1) : len;
    for (i = 0; i < cut; i++) begin
      do b = BYTE_W'($urandom); while (b == CH_CR);
      rx_stream.push_back(b);
    end
    if (kind == FR_TRAILING) begin
      do b = BYTE_W'($urandom); while (b == CH_CR);
      rx_stream.push_back(b);
    end else begin
      rx_stream.push_back(CH_CR);
    end
  endtask

  // result side: ready dropped in bursts of random length
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // byte side: builds the stream, then sends it one beat at a time
  initial begin
    int unsigned n;
    int unsigned pause_at;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    frame_kind_t kind;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;

    // directed: empty frame with the lowest code, a cr that cuts the
    // payload short under the highest code, a length that is not a number
    queue_frame(FR_GOOD, 0, 8'h00);
    queue_frame(FR_EARLY_CR, 1, 8'hFF);
    queue_frame(FR_BAD_DIGIT, 0, 8'h80);

    // store boundary: last length that fits, first that spills, the largest
    stop_at = rx_stream.size() + RANDOM_BYTES;
    queue_frame(FR_GOOD, MAX_PAYLOAD, BYTE_W'($urandom));
    queue_frame(FR_GOOD, MAX_PAYLOAD + 1, BYTE_W'($urandom));
    queue_frame(FR_GOOD, 99, BYTE_W'($urandom));
    queue_frame(FR_TRAILING, 3, BYTE_W'($urandom));

    // mostly well-formed frames with random content, long ones rare
    while (rx_stream.size() < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      kind = FR_GOOD;
      else if (pick < 71) kind = FR_EARLY_CR;
      else if (pick < 79) kind = FR_TRAILING;
      else if (pick < 86) kind = FR_BAD_DIGIT;
      else if (pick < 93) kind = FR_BAD_HEADER;
      else                kind = FR_NOISE;
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(MAX_PAYLOAD + 1, 99)
                                         : $urandom_range(0, 12);
      if (kind == FR_EARLY_CR && len == 0) len = 1;
      queue_frame(kind, len, BYTE_W'($urandom));
    end
    pause_at = rx_stream.size() / 2;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < rx_stream.size(); n++) begin
      calm = (n + CALM_TAIL >= rx_stream.size());
      if (n == pause_at) begin
        // hold off until the parser has handed back every result
        in_ch.valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.rx_byte <= rx_stream[n];
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: too long without a beat on either channel ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
src/scfp_pkg.sv
src/scfp_if.sv
src/scfp_step.sv
src/serial_command_frame_parser.sv
tb/sv/frame_result_checker.sv
tb/sv/testbench.sv
